### src/assert_macros.svh
// assertion macros used by the deque top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("deque assertion failed");

// next-cycle implication, disabled during reset
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("deque assertion failed");

`endif

### src/bdq_pkg.sv
// types, codes and defaults for the bounded double-ended queue
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int WORD_WIDTH_DEFAULT = 32;
	localparam int OP_W               = 3;
	localparam int FIELD_W            = 32;
	localparam int COUNT_FIELD_W      = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_TOP    = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BOTTOM = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_TOP     = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BOTTOM  = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_TOP    = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK_BOTTOM = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [FIELD_W-1:0] push_value;
	} bdq_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0]       read_value;
		logic                     error;
		logic [COUNT_FIELD_W-1:0] count;
		logic                     is_empty;
	} bdq_res_t;

	// per-cycle command broadcast to every cell
	// row a keeps the bottom word in cell 0, row b keeps the top word in cell 0
	typedef struct packed {
		logic a_shift_up;
		logic a_shift_down;
		logic a_load;
		logic b_shift_up;
		logic b_shift_down;
		logic b_load;
	} bdq_ctrl_t;

endpackage

### src/bounded_double_ended_queue.sv
// top level of the bounded double-ended queue
// Usage:
//   Drive cmd and raise start; a command transfer happens at a rising edge
//   with start high and busy low. busy stays low, so one command can be
//   given in every cycle.
//   Each command yields one result on rsp, marked by done for exactly one
//   cycle, the cycle right after the command transfer.
//   Throughput is one command per cycle: every cell of the chain shifts or
//   loads in the same cycle, and both ends of the queue sit in cell 0 of
//   one of two rows (row a holds the bottom word there, row b the top word).
//   A push that finds the queue full, or a pop or peek on an empty queue,
//   returns error with read_value zero and leaves the contents unchanged.
//   Reset empties the queue at once; cell contents are not cleared and are
//   never read before they are written.
//   The receiver cannot stall: done marks a result for one cycle only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_double_ended_queue #(
	parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
	parameter int WORD_WIDTH = bdq_pkg::WORD_WIDTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bdq_pkg::bdq_req_t cmd,
	output logic              done,
	output bdq_pkg::bdq_res_t rsp
);

	localparam int COUNT_W = $clog2(DEPTH + 1);

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [COUNT_W-1:0]    cnt_q;
	logic [COUNT_W-1:0]    cnt_next;
	logic [63:0]           push_wide;
	logic [WORD_WIDTH-1:0] push_word;
	logic [WORD_WIDTH-1:0] rd_word;
	logic                  err;
	logic [63:0]           rd_wide;
	logic [63:0]           cnt_wide;
	bdq_pkg::bdq_ctrl_t    ctrl;
	logic                  done_q;
	bdq_pkg::bdq_res_t     rsp_q;
	logic [WORD_WIDTH-1:0] a_word [DEPTH];
	logic [WORD_WIDTH-1:0] b_word [DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (cnt_q == COUNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);

	// push word kept to the word width
	assign push_wide = 64'(cmd.push_value);
	assign push_word = push_wide[WORD_WIDTH-1:0];

	// decode the command into chain moves, read word and new fill
	always_comb begin
		ctrl     = '0;
		rd_word  = '0;
		err      = 1'b0;
		cnt_next = cnt_q;
		if (accept) begin
			case (cmd.op)
				bdq_pkg::OP_PUSH_TOP: begin
					if (full) begin
						err = 1'b1;
					end else begin
						ctrl.b_shift_up = 1'b1;
						ctrl.a_load     = 1'b1;
						cnt_next        = cnt_q + 1'b1;
					end
				end
				bdq_pkg::OP_PUSH_BOTTOM: begin
					if (full) begin
						err = 1'b1;
					end else begin
						ctrl.a_shift_up = 1'b1;
						ctrl.b_load     = 1'b1;
						cnt_next        = cnt_q + 1'b1;
					end
				end
				bdq_pkg::OP_POP_TOP: begin
					if (empty) begin
						err = 1'b1;
					end else begin
						rd_word           = b_word[0];
						ctrl.b_shift_down = 1'b1;
						cnt_next          = cnt_q - 1'b1;
					end
				end
				bdq_pkg::OP_POP_BOTTOM: begin
					if (empty) begin
						err = 1'b1;
					end else begin
						rd_word           = a_word[0];
						ctrl.a_shift_down = 1'b1;
						cnt_next          = cnt_q - 1'b1;
					end
				end
				bdq_pkg::OP_PEEK_TOP: begin
					if (empty) begin
						err = 1'b1;
					end else begin
						rd_word = b_word[0];
					end
				end
				bdq_pkg::OP_PEEK_BOTTOM: begin
					if (empty) begin
						err = 1'b1;
					end else begin
						rd_word = a_word[0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// chain of cells; shift-in at cell 0, zero fed past the last cell
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] a_below;
		logic [WORD_WIDTH-1:0] a_above;
		logic [WORD_WIDTH-1:0] b_below;
		logic [WORD_WIDTH-1:0] b_above;

		if (i == 0) begin : g_first
			assign a_below = push_word;
			assign b_below = push_word;
		end else begin : g_inner_lo
			assign a_below = a_word[i-1];
			assign b_below = b_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign a_above = '0;
			assign b_above = '0;
		end else begin : g_inner_hi
			assign a_above = a_word[i+1];
			assign b_above = b_word[i+1];
		end

		bdq_cell #(
			.WORD_WIDTH (WORD_WIDTH),
			.COUNT_W    (COUNT_W),
			.CELL_INDEX (i)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.fill         (cnt_q),
			.load_word    (push_word),
			.a_from_below (a_below),
			.a_from_above (a_above),
			.b_from_below (b_below),
			.b_from_above (b_above),
			.a_word       (a_word[i]),
			.b_word       (b_word[i])
		);
	end

	// fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_next;
			done_q <= accept;
		end
	end

	// result payload
	assign rd_wide  = 64'(rd_word);
	assign cnt_wide = 64'(cnt_next);

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.read_value <= rd_wide[bdq_pkg::FIELD_W-1:0];
			rsp_q.error      <= err;
			rsp_q.count      <= cnt_wide[bdq_pkg::COUNT_FIELD_W-1:0];
			rsp_q.is_empty   <= (cnt_next == '0);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// a result follows every command transfer
	`BDQ_ASSERT_NEXT(a_done_follows, clk, arst_n, accept, done)

	// a push into a full queue is flagged and leaves the fill alone
	`BDQ_ASSERT_NEXT(a_push_full, clk, arst_n,
		accept && full && (cmd.op == bdq_pkg::OP_PUSH_TOP || cmd.op == bdq_pkg::OP_PUSH_BOTTOM),
		rsp.error && cnt_q == $past(cnt_q))

	// a pop on a non-empty queue removes exactly one word
	`BDQ_ASSERT_NEXT(a_pop_count, clk, arst_n,
		accept && !empty && (cmd.op == bdq_pkg::OP_POP_TOP || cmd.op == bdq_pkg::OP_POP_BOTTOM),
		!rsp.error && cnt_q == $past(cnt_q) - 1'b1)

	// empty flag agrees with the reported fill
	`BDQ_ASSERT_NOW(a_empty_flag, clk, arst_n, done, rsp.is_empty == (cnt_q == '0))

endmodule

### src/bdq_cell.sv
// one storage cell of the deque chain, one word of each row
`timescale 1ns / 1ps

module bdq_cell #(
	parameter int WORD_WIDTH = bdq_pkg::WORD_WIDTH_DEFAULT,
	parameter int COUNT_W    = 5,
	parameter int CELL_INDEX = 0
) (
	input  logic                  clk,
	input  bdq_pkg::bdq_ctrl_t    ctrl,
	input  logic [COUNT_W-1:0]    fill,
	input  logic [WORD_WIDTH-1:0] load_word,
	input  logic [WORD_WIDTH-1:0] a_from_below,
	input  logic [WORD_WIDTH-1:0] a_from_above,
	input  logic [WORD_WIDTH-1:0] b_from_below,
	input  logic [WORD_WIDTH-1:0] b_from_above,
	output logic [WORD_WIDTH-1:0] a_word,
	output logic [WORD_WIDTH-1:0] b_word
);

	logic [WORD_WIDTH-1:0] a_q;
	logic [WORD_WIDTH-1:0] b_q;
	logic                  at_fill;

	// this cell is the first free slot of both rows
	assign at_fill = (fill == COUNT_W'(CELL_INDEX));

	// row a: shift toward higher cells, toward lower cells, or load at the free end
	always_ff @(posedge clk) begin
		if (ctrl.a_shift_up) begin
			a_q <= a_from_below;
		end else if (ctrl.a_shift_down) begin
			a_q <= a_from_above;
		end else if (ctrl.a_load && at_fill) begin
			a_q <= load_word;
		end
	end

	// row b: same moves, mirrored end of the queue
	always_ff @(posedge clk) begin
		if (ctrl.b_shift_up) begin
			b_q <= b_from_below;
		end else if (ctrl.b_shift_down) begin
			b_q <= b_from_above;
		end else if (ctrl.b_load && at_fill) begin
			b_q <= load_word;
		end
	end

	assign a_word = a_q;
	assign b_word = b_q;

endmodule
